>>> rtl/lkhc_pkg.sv
// ----------------------------------------------------------------------------
// lkhc_pkg
// Shared types, constants and register defaults of the line keyword hit
// counter.
// ----------------------------------------------------------------------------
package lkhc_pkg;

  localparam int unsigned KEYWORD_BYTES_DEF = 8;
  localparam int unsigned KEYWORD_COUNT_DEF = 5;

  localparam int unsigned KW_REGS  = 5;
  localparam int unsigned WIN_MAX  = 8;
  localparam int unsigned KW_W     = 64;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned PADDR_W  = 6;
  localparam int unsigned COUNT_W  = 31;

  typedef logic [KW_W-1:0]    kw_word_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [KW_REGS-1:0] hit_t;

  localparam count_t COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  typedef enum logic [1:0] {
    ACT_BYTE  = 2'd0,
    ACT_EOL   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  // Keyword register indexes.
  localparam logic [2:0] REG_KEYWORD_A = 3'd0;
  localparam logic [2:0] REG_KEYWORD_B = 3'd1;
  localparam logic [2:0] REG_KEYWORD_C = 3'd2;
  localparam logic [2:0] REG_KEYWORD_D = 3'd3;
  localparam logic [2:0] REG_KEYWORD_E = 3'd4;

  // Reset values spell error, warning, critical, info and debug.
  localparam kw_word_t KW_DEFAULTS [KW_REGS] = '{
    64'd491496043109,
    64'd29113321704808823,
    64'd7809632533412934243,
    64'd1868983913,
    64'd444351014244
  };

  typedef struct packed {
    logic eol;
    logic clear;
    hit_t hits;
  } line_evt_t;

endpackage

>>> rtl/lkhc_in_if.sv
// ----------------------------------------------------------------------------
// lkhc_in_if
// Input channel: one text byte or line command per beat.
// ----------------------------------------------------------------------------
interface lkhc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] text_byte;

  modport source (output valid, action, text_byte, input ready);
  modport sink   (input valid, action, text_byte, output ready);
endinterface

>>> rtl/lkhc_out_if.sv
// ----------------------------------------------------------------------------
// lkhc_out_if
// Result channel: hit mask of the finished line and all keyword counts.
// ----------------------------------------------------------------------------
interface lkhc_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  line_hit_mask;
  logic [30:0] count_a;
  logic [30:0] count_b;
  logic [30:0] count_c;
  logic [30:0] count_d;
  logic [30:0] count_e;

  modport source (output valid, line_hit_mask, count_a, count_b, count_c, count_d,
                  count_e, input ready);
  modport sink   (input valid, line_hit_mask, count_a, count_b, count_c, count_d,
                  count_e, output ready);
endinterface

>>> rtl/lkhc_cfg_regs.sv
// ----------------------------------------------------------------------------
// lkhc_cfg_regs
// APB-style register file holding the five keyword words.
// ----------------------------------------------------------------------------
module lkhc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lkhc_pkg::PADDR_W-1:0]  paddr,
  input  logic [lkhc_pkg::DATA_W-1:0]   pwdata,
  output logic [lkhc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output lkhc_pkg::kw_word_t            kw_o [lkhc_pkg::KW_REGS]
);
  import lkhc_pkg::*;

  kw_word_t   kw_q [KW_REGS];
  logic [2:0] reg_idx;
  logic       wr_en;

  // Registers sit on 8-byte boundaries; the low address bits are not decoded.
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < KW_REGS; k++) kw_q[k] <= KW_DEFAULTS[k];
    end else if (wr_en) begin
      for (int k = 0; k < KW_REGS; k++) begin
        if (reg_idx == 3'(k)) kw_q[k] <= pwdata;
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx <= REG_KEYWORD_E) prdata = kw_q[reg_idx];
  end

  assign kw_o = kw_q;

endmodule

>>> rtl/lkhc_matcher.sv
// ----------------------------------------------------------------------------
// lkhc_matcher
// Byte window of the current line and parallel keyword compare lanes that
// collect the sticky per-line hit bits.
// ----------------------------------------------------------------------------
module lkhc_matcher #(
  parameter int unsigned KEYWORD_BYTES = lkhc_pkg::KEYWORD_BYTES_DEF,
  parameter int unsigned KEYWORD_COUNT = lkhc_pkg::KEYWORD_COUNT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [1:0]          action_i,
  input  logic [7:0]          text_byte_i,
  input  lkhc_pkg::kw_word_t  kw_i [lkhc_pkg::KW_REGS],
  output lkhc_pkg::line_evt_t evt_o
);
  import lkhc_pkg::*;

  localparam int unsigned FW        = $clog2(KEYWORD_BYTES + 1);
  localparam int unsigned NUM_LANES = (KEYWORD_COUNT < KW_REGS) ? KEYWORD_COUNT : KW_REGS;

  logic [7:0]    win_q [KEYWORD_BYTES];
  logic [7:0]    win_shift [KEYWORD_BYTES];
  logic [FW-1:0] fill_q, fill_d;
  hit_t          hits_q, hits_d, hit_new;
  logic [7:0]    ch;
  action_e       act;

  assign act = action_e'(action_i);
  assign ch  = (text_byte_i >= CHAR_UPPER_A && text_byte_i <= CHAR_UPPER_Z) ?
               text_byte_i + CASE_OFFSET : text_byte_i;

  always_comb begin
    win_shift[0] = ch;
    for (int j = 1; j < KEYWORD_BYTES; j++) win_shift[j] = win_q[j-1];
  end

  // The fill count saturates at the window depth, which is all a compare needs.
  assign fill_d = (fill_q == FW'(KEYWORD_BYTES)) ? fill_q : fill_q + FW'(1);

  for (genvar k = 0; k < KW_REGS; k++) begin : g_lane
    if (k < NUM_LANES) begin : g_on
      logic [FW-1:0]          len;
      logic                   stop;
      logic [KEYWORD_BYTES:0] m;

      always_comb begin
        len  = '0;
        stop = 1'b0;
        for (int n = 0; n < KEYWORD_BYTES; n++) begin
          if (!stop) begin
            if (kw_i[k][8*n +: 8] != 8'd0) len = FW'(n + 1);
            else stop = 1'b1;
          end
        end
      end

      // m[L] is set when the newest L bytes spell the first L keyword bytes.
      always_comb begin
        m[0] = 1'b0;
        for (int l = 1; l <= KEYWORD_BYTES; l++) begin
          m[l] = 1'b1;
          for (int i = 0; i < l; i++) begin
            if (win_shift[l-1-i] != kw_i[k][8*i +: 8]) m[l] = 1'b0;
          end
        end
      end

      assign hit_new[k] = (len != '0) && (fill_d >= len) && m[len];
    end else begin : g_off
      assign hit_new[k] = 1'b0;
    end
  end

  assign hits_d = hits_q | hit_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      hits_q <= '0;
    end else if (accept_i) begin
      unique case (act)
        ACT_BYTE: begin
          fill_q <= fill_d;
          hits_q <= hits_d;
        end
        ACT_EOL: begin
          fill_q <= '0;
          hits_q <= '0;
        end
        default: ;
      endcase
    end
  end

  // Window bytes beyond the fill count are never compared, so stale bytes
  // from an earlier line need no clearing.
  always_ff @(posedge clk_i) begin
    if (accept_i && act == ACT_BYTE) win_q <= win_shift;
  end

  assign evt_o.eol   = accept_i && (act == ACT_EOL);
  assign evt_o.clear = accept_i && (act == ACT_CLEAR);
  assign evt_o.hits  = hits_q;

endmodule

>>> rtl/lkhc_counters.sv
// ----------------------------------------------------------------------------
// lkhc_counters
// Saturating per-keyword line counters and the registered result stage.
// ----------------------------------------------------------------------------
module lkhc_counters (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lkhc_pkg::line_evt_t evt_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output lkhc_pkg::hit_t      mask_o,
  output lkhc_pkg::count_t    count_o [lkhc_pkg::KW_REGS]
);
  import lkhc_pkg::*;

  count_t counts_q [KW_REGS];
  count_t counts_d [KW_REGS];
  count_t res_q    [KW_REGS];
  hit_t   mask_q;
  logic   valid_q;

  always_comb begin
    for (int k = 0; k < KW_REGS; k++) begin
      counts_d[k] = counts_q[k];
      if (evt_i.hits[k] && counts_q[k] != COUNT_MAX) counts_d[k] = counts_q[k] + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < KW_REGS; k++) counts_q[k] <= '0;
      valid_q <= 1'b0;
    end else begin
      priority if (evt_i.clear) begin
        for (int k = 0; k < KW_REGS; k++) counts_q[k] <= '0;
      end else if (evt_i.eol) begin
        counts_q <= counts_d;
      end
      if (evt_i.eol) valid_q <= 1'b1;
      else if (out_ready_i) valid_q <= 1'b0;
    end
  end

  // The result beat keeps its own copy so later clears cannot disturb it.
  always_ff @(posedge clk_i) begin
    if (evt_i.eol) begin
      res_q  <= counts_d;
      mask_q <= evt_i.hits;
    end
  end

  assign out_valid_o = valid_q;
  assign mask_o      = mask_q;
  assign count_o     = res_q;

endmodule

>>> rtl/line_keyword_hit_counter.sv
// ----------------------------------------------------------------------------
// line_keyword_hit_counter
// Counts, per keyword, the text lines that contain it.
// ----------------------------------------------------------------------------
// The result beat of an end of line is valid in the cycle after it is
// accepted. Throughput: one input beat per cycle; the single result register
// holds input only while an unread result sits in it. Reset restores the
// default keywords and clears the counters, line state and result valid bit.
module line_keyword_hit_counter #(
  parameter int unsigned KEYWORD_BYTES = lkhc_pkg::KEYWORD_BYTES_DEF,
  parameter int unsigned KEYWORD_COUNT = lkhc_pkg::KEYWORD_COUNT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lkhc_in_if.sink                       in_i,
  lkhc_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lkhc_pkg::PADDR_W-1:0]  paddr,
  input  logic [lkhc_pkg::DATA_W-1:0]   pwdata,
  output logic [lkhc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import lkhc_pkg::*;

  kw_word_t  kw [KW_REGS];
  line_evt_t evt;
  count_t    counts [KW_REGS];
  hit_t      mask;
  logic      out_valid;
  logic      accept;

  assign in_i.ready = !out_valid || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  lkhc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .kw_o    (kw)
  );

  lkhc_matcher #(
    .KEYWORD_BYTES (KEYWORD_BYTES),
    .KEYWORD_COUNT (KEYWORD_COUNT)
  ) u_match (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .action_i    (in_i.action),
    .text_byte_i (in_i.text_byte),
    .kw_i        (kw),
    .evt_o       (evt)
  );

  lkhc_counters u_cnt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_i       (evt),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .mask_o      (mask),
    .count_o     (counts)
  );

  assign out_o.valid         = out_valid;
  assign out_o.line_hit_mask = mask;
  assign out_o.count_a       = counts[REG_KEYWORD_A];
  assign out_o.count_b       = counts[REG_KEYWORD_B];
  assign out_o.count_c       = counts[REG_KEYWORD_C];
  assign out_o.count_d       = counts[REG_KEYWORD_D];
  assign out_o.count_e       = counts[REG_KEYWORD_E];

endmodule

>>> rtl/lkhc_checker.sv
// ----------------------------------------------------------------------------
// lkhc_checker
// Port-level checks of the line keyword hit counter, bound to the top level.
// ----------------------------------------------------------------------------
module lkhc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [1:0]  in_action_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [4:0]  out_mask_i,
  input logic [30:0] out_count_a_i
);
  import lkhc_pkg::*;

  logic eol_beat;
  assign eol_beat = in_valid_i && in_ready_i && (in_action_i == ACT_EOL);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_mask_i) &&
                                    $stable(out_count_a_i))
    else $error("result beat changed while stalled");

  // Every accepted end of line yields a result beat in the next cycle.
  a_eol_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eol_beat |=> out_valid_i)
    else $error("end of line produced no result");

  // A result beat only appears after an end of line.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(eol_beat))
    else $error("result beat without end of line");

  // With the result register empty, input is always taken.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty result register");

endmodule

bind line_keyword_hit_counter lkhc_checker u_lkhc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_action_i   (in_i.action),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_mask_i    (out_o.line_hit_mask),
  .out_count_a_i (out_o.count_a)
);

>>> tb/lkhc_tally_checker.sv
// ----------------------------------------------------------------------------
// lkhc_tally_checker
// Watches the text channel, the result channel and the register port of the
// line keyword hit counter. It keeps its own copy of the keywords, the line
// window and the counters, predicts the tally of every finished line and
// compares each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module lkhc_tally_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  lkhc_in_if                           in_mon,
  lkhc_out_if                          out_mon,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [lkhc_pkg::PADDR_W-1:0] paddr,
  input  logic [lkhc_pkg::DATA_W-1:0]  pwdata,
  output int                           fail_count_o,
  output int                           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import lkhc_pkg::*;

  typedef struct packed {
    hit_t                 mask;
    count_t [KW_REGS-1:0] counts;
  } line_tally_t;

  kw_word_t    keywords [KW_REGS];
  logic [7:0]  window [WIN_MAX];
  int unsigned line_fill;
  hit_t        line_hits;
  count_t      counts [KW_REGS];
  line_tally_t expected_tallies [$];
  line_tally_t want;
  line_tally_t got;
  logic [2:0]  reg_index;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count_o++;
  endtask

  function automatic int unsigned keyword_length(kw_word_t w);
    int unsigned n;
    n = 0;
    while (n < KEYWORD_BYTES_DEF && n < WIN_MAX && w[8*n +: 8] != 8'h00) n++;
    return n;
  endfunction

  // The window holds the newest byte in entry 0, so the last keyword
  // character lines up with entry 0 and the first with entry len-1.
  function automatic logic keyword_hit(kw_word_t w);
    int unsigned len;
    len = keyword_length(w);
    if (len == 0 || line_fill < len) return 1'b0;
    for (int unsigned i = 0; i < len; i++) begin
      if (window[len-1-i] != w[8*i +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic predict_line_tally(input action_e act, input logic [7:0] ch);
    logic [7:0]  folded;
    line_tally_t tally;
    case (act)
      ACT_BYTE: begin
        folded = ch;
        if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) folded = ch + CASE_OFFSET;
        for (int i = WIN_MAX - 1; i > 0; i--) window[i] = window[i-1];
        window[0] = folded;
        if (line_fill < WIN_MAX) line_fill++;
        for (int k = 0; k < KW_REGS && k < KEYWORD_COUNT_DEF; k++) begin
          if (keyword_hit(keywords[k])) line_hits[k] = 1'b1;
        end
      end
      ACT_EOL: begin
        for (int k = 0; k < KW_REGS; k++) begin
          if (line_hits[k] && counts[k] != COUNT_MAX) counts[k]++;
          tally.counts[k] = counts[k];
        end
        tally.mask = line_hits;
        expected_tallies.insert(expected_tallies.size(), tally);
        for (int i = 0; i < WIN_MAX; i++) window[i] = 8'h00;
        line_fill = 0;
        line_hits = '0;
      end
      ACT_CLEAR: begin
        for (int k = 0; k < KW_REGS; k++) counts[k] = '0;
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < KW_REGS; k++) begin
        keywords[k] = KW_DEFAULTS[k];
        counts[k]   = '0;
      end
      for (int i = 0; i < WIN_MAX; i++) window[i] = 8'h00;
      line_fill = 0;
      line_hits = '0;
      expected_tallies.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        reg_index = paddr[PADDR_W-1:3];
        if (reg_index < KW_REGS) keywords[reg_index] = pwdata;
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_line_tally(action_e'(in_mon.action), in_mon.text_byte);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_tallies.size() == 0) begin
          report_mismatch("result beat arrived with no line pending");
        end else begin
          want = expected_tallies.pop_front();
          got.mask      = out_mon.line_hit_mask;
          got.counts[0] = out_mon.count_a;
          got.counts[1] = out_mon.count_b;
          got.counts[2] = out_mon.count_c;
          got.counts[3] = out_mon.count_d;
          got.counts[4] = out_mon.count_e;
          if (got.mask != want.mask) begin
            report_mismatch($sformatf("line_hit_mask got %05b want %05b",
                                      got.mask, want.mask));
          end
          for (int k = 0; k < KW_REGS; k++) begin
            if (got.counts[k] != want.counts[k]) begin
              report_mismatch($sformatf("count_%c got %0d want %0d", 8'h61 + k,
                                        got.counts[k], want.counts[k]));
            end
          end
        end
      end
      pending_o = expected_tallies.size();
    end
  end

endmodule

>>> tb/line_keyword_hit_counter_test.sv
// ----------------------------------------------------------------------------
// line_keyword_hit_counter_test
// Drives text lines, clear and idle commands into the keyword hit counter
// under random flow control, rewrites the keywords between phases and leaves
// the checking to lkhc_tally_checker.
// ----------------------------------------------------------------------------
module line_keyword_hit_counter_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lkhc_pkg::*;

  localparam int         RANDOM_ITEMS = 700;
  localparam int         PHASES       = 4;
  localparam int         HOLD_CYCLES  = 200;
  localparam int         CYCLE_LIMIT  = 200000;
  localparam logic [2:0] REG_UNMAPPED = 3'd5;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  int       fail_count;
  int       lines_pending;
  int       cycle_count = 0;
  int       items_sent  = 0;
  int       hold_left   = 0;
  bit       hold_req    = 1'b0;
  bit       hold_done   = 1'b0;
  bit       calm        = 1'b0;
  kw_word_t keyword_set [KW_REGS];

  lkhc_in_if  text_ch ();
  lkhc_out_if tally_ch ();

  line_keyword_hit_counter DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (text_ch),
    .out_o   (tally_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  lkhc_tally_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (text_ch),
    .out_mon      (tally_ch),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (lines_pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("line_keyword_hit_counter_test: errors");
      $finish;
    end
  end

  // Result side: random stalls, a calm phase, and one long hold-off that lets
  // the result register fill so that the text channel backs up.
  initial begin
    tally_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        tally_ch.ready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        tally_ch.ready <= 1'b0;
      end else begin
        tally_ch.ready <= calm || ($urandom_range(99) >= 14);
      end
    end
  end

  task automatic send_beat(input action_e act, input logic [7:0] ch);
    while (!calm && $urandom_range(99) < 14) begin
      text_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    text_ch.valid     <= 1'b1;
    text_ch.action    <= act;
    text_ch.text_byte <= ch;
    @(posedge clk_i);
    while (!text_ch.ready) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(ACT_BYTE, s[i]);
  endtask

  // Waits until every finished line has been reported, then idles on so that
  // nothing is still moving inside the block.
  task automatic quiesce();
    text_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (lines_pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_keyword(input logic [2:0] index, input kw_word_t value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 3'b000};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (index < KW_REGS) keyword_set[index] = value;
  endtask

  // Keywords mostly use a three-letter alphabet so that random text hits them.
  function automatic kw_word_t rand_keyword(int min_len, int max_len);
    int       len;
    int       r;
    kw_word_t w;
    w   = '0;
    len = (min_len <= 1 && $urandom_range(19) == 0) ? 0 : $urandom_range(max_len, min_len);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (r < 5) w[8*i +: 8] = 8'($urandom_range(255, 1));
      else if (r < 12) w[8*i +: 8] = CHAR_UPPER_A + 8'($urandom_range(2));
      else w[8*i +: 8] = 8'h61 + 8'($urandom_range(2));
    end
    // Junk after the terminating zero must be ignored.
    if (len < 7 && $urandom_range(9) == 0) w[63:56] = 8'($urandom_range(255, 1));
    return w;
  endfunction

  function automatic logic [7:0] rand_text_byte();
    logic [7:0] c;
    if ($urandom_range(99) < 15) return 8'($urandom_range(255));
    c = 8'h61 + 8'($urandom_range(2));
    if ($urandom_range(1) == 1) c = c - CASE_OFFSET;
    return c;
  endfunction

  task automatic send_random_line();
    int         len;
    int         pos;
    kw_word_t   w;
    logic [7:0] c;
    len = ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(10);
    pos = ($urandom_range(9) < 4) ? $urandom_range(len) : -1;
    w   = keyword_set[3'($urandom_range(KW_REGS - 1))];
    for (int i = 0; i <= len; i++) begin
      if (i == pos) begin
        for (int n = 0; n < 8 && w[8*n +: 8] != 8'h00; n++) begin
          c = w[8*n +: 8];
          if (c >= 8'h61 && c <= 8'h7a && $urandom_range(1) == 1) c = c - CASE_OFFSET;
          send_beat(ACT_BYTE, c);
        end
      end
      if (i < len) send_beat(ACT_BYTE, rand_text_byte());
    end
    send_beat(ACT_EOL, 8'($urandom_range(255)));
  endtask

  initial begin
    int phase_start;
    int r;
    bit paused;
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    text_ch.valid     = 1'b0;
    text_ch.action    = ACT_NOP;
    text_ch.text_byte = 8'h00;
    for (int k = 0; k < KW_REGS; k++) keyword_set[k] = KW_DEFAULTS[k];
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Default keywords: empty line, mixed-case hit, boundary and control
    // bytes, then an idle beat and a clear before another hit.
    send_beat(ACT_EOL, 8'h00);
    send_text("ErrOR");
    send_beat(ACT_EOL, 8'hff);
    send_beat(ACT_BYTE, 8'h00);
    send_beat(ACT_BYTE, 8'hff);
    send_text("@AZ[");
    send_beat(ACT_BYTE, 8'h0a);
    send_beat(ACT_EOL, 8'h00);
    send_beat(ACT_NOP, 8'h5a);
    send_beat(ACT_CLEAR, 8'h00);
    send_text("deBUG");
    send_beat(ACT_EOL, 8'h00);

    // Disabled keyword, all-ones keyword that needs a full window, an
    // upper-case keyword that can never hit, junk after a zero byte, a
    // one-character keyword and a write to an unmapped register.
    quiesce();
    write_keyword(REG_KEYWORD_A, '0);
    write_keyword(REG_KEYWORD_B, '1);
    write_keyword(REG_KEYWORD_C, 64'h0000_0000_0063_6241);
    write_keyword(REG_KEYWORD_D, 64'h0000_0000_0079_0078);
    write_keyword(REG_KEYWORD_E, 64'h0000_0000_0000_0071);
    write_keyword(REG_UNMAPPED, '1);
    repeat (8) send_beat(ACT_BYTE, 8'hff);
    send_text("aBcxyQ");
    send_beat(ACT_EOL, 8'h00);

    for (int p = 0; p < PHASES; p++) begin
      quiesce();
      calm = 1'b0;
      for (int k = 0; k < KW_REGS; k++) begin
        if (p == PHASES - 1) write_keyword(k[2:0], rand_keyword(k == 0 ? 8 : 1, 8));
        else write_keyword(k[2:0], rand_keyword(1, 3));
      end
      calm = (p == 1);
      if (p == 2) hold_req = 1'b1;
      paused      = 1'b0;
      phase_start = items_sent;
      while (items_sent - phase_start < RANDOM_ITEMS / PHASES) begin
        if (p == 2 && !paused && items_sent - phase_start > RANDOM_ITEMS / PHASES / 2) begin
          quiesce();
          paused = 1'b1;
        end
        r = $urandom_range(99);
        if (r < 5) send_beat(ACT_CLEAR, 8'($urandom_range(255)));
        else if (r < 8) send_beat(ACT_NOP, 8'($urandom_range(255)));
        else send_random_line();
      end
    end

    quiesce();
    repeat (10) @(negedge clk_i);
    if (fail_count == 0 && lines_pending == 0) begin
      $display("line_keyword_hit_counter_test: clean");
    end else begin
      $display("line_keyword_hit_counter_test: errors");
    end
    $finish;
  end

endmodule
